/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// ante in one cycle implies cons in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/ssht_pkg.sv */
// ----------------------------------------------------------------------------
// Swept sphere hit test package
// Widths, index codes and stage flag type for the swept sphere hit test.
// ----------------------------------------------------------------------------
package ssht_pkg;

   localparam int COORD_W  = 16;
   localparam int RAD_W    = 15;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int DOT_W    = SQ_W + 1;
   localparam int SUM_W    = SQ_W + 2;
   localparam int T_W      = SUM_W + 1;
   localparam int RSUM_W   = RAD_W + 1;
   localparam int RSQ_W    = 2 * RSUM_W;
   localparam int HALF_W   = SUM_W / 2;
   localparam int PP_W     = 2 * HALF_W;
   localparam int CROSS_W  = PP_W + 1;
   localparam int PROD_W   = 2 * SUM_W;

   localparam int AXES       = 3;
   localparam int NUM_PROD   = 3;
   localparam int NUM_PP     = 4;
   localparam int NUM_STAGES = 8;

   localparam int PROD_WL  = 0;
   localparam int PROD_RL  = 1;
   localparam int PROD_TT  = 2;

   localparam int PP_HH    = 0;
   localparam int PP_HL    = 1;
   localparam int PP_LH    = 2;
   localparam int PP_LL    = 3;

   typedef struct packed {
      logic near;
      logic far;
      logic near_hit;
      logic far_hit;
   } flags_type;

endpackage

/* hw/rtl/swept_sphere_hit_test_core.sv */
// ----------------------------------------------------------------------------
// Swept sphere hit test core
// Segment-versus-sphere test of a moving sphere against a target sphere,
// exact integer arithmetic, eight register stages.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | prev, cur, mover radius, target
//   rsp     | out       | rsp_valid/rsp_stall | hit
//
// One transaction accepted per cycle while req_stall is low, before earlier ones finish.
// Latency is set by the split 34x34 products (partial products, cross sum,
// assembly, add, compare). Reset clears the stage valid bits only.
// A stalled result holds stage eight; earlier stages keep filling bubbles,
// and req_stall rises only when every stage holds a transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swept_sphere_hit_test_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_prev_x,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_prev_y,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_prev_z,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_cur_x,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_cur_y,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_cur_z,
   input  logic        [ssht_pkg::RAD_W-1:0]    req_mover_radius,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [ssht_pkg::COORD_W-1:0]  req_target_z,
   input  logic        [ssht_pkg::RAD_W-1:0]    req_target_radius,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit
);

   logic [ssht_pkg::NUM_STAGES-1:0] stage_valid_ff;
   logic [ssht_pkg::NUM_STAGES-1:0] stage_valid_in;
   logic [ssht_pkg::NUM_STAGES-1:0] stage_en;

   // stage 1: differences
   logic signed [ssht_pkg::DIFF_W-1:0] d_in [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W-1:0] w_in [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W-1:0] e_in [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W-1:0] d_ff [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W-1:0] w_ff [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W-1:0] e_ff [ssht_pkg::AXES];
   logic        [ssht_pkg::RSUM_W-1:0] rsum_in;
   logic        [ssht_pkg::RSUM_W-1:0] rsum_ff;

   // stage 2: per-axis products
   logic signed [ssht_pkg::DIFF_W*2-1:0] dd_full [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W*2-1:0] ww_full [ssht_pkg::AXES];
   logic signed [ssht_pkg::DIFF_W*2-1:0] ee_full [ssht_pkg::AXES];
   logic        [ssht_pkg::SQ_W-1:0]     dd_ff [ssht_pkg::AXES];
   logic        [ssht_pkg::SQ_W-1:0]     ww_ff [ssht_pkg::AXES];
   logic        [ssht_pkg::SQ_W-1:0]     ee_ff [ssht_pkg::AXES];
   logic signed [ssht_pkg::DOT_W-1:0]    wd_in [ssht_pkg::AXES];
   logic signed [ssht_pkg::DOT_W-1:0]    wd_ff [ssht_pkg::AXES];
   logic        [ssht_pkg::RSQ_W-1:0]    rsq_in;
   logic        [ssht_pkg::RSQ_W-1:0]    rsq_ff;

   // stage 3: sums
   logic        [ssht_pkg::SUM_W-1:0] len2_in, w2_in, e2_in;
   logic        [ssht_pkg::SUM_W-1:0] len2_ff, w2_ff, e2_ff;
   logic signed [ssht_pkg::T_W-1:0]   t_in;
   logic signed [ssht_pkg::T_W-1:0]   t_ff;
   logic        [ssht_pkg::RSQ_W-1:0] rsq3_ff;

   // stage 4: classification and partial products
   ssht_pkg::flags_type f4_in, f4_ff, f5_ff, f6_ff, f7_ff;
   logic [ssht_pkg::SUM_W-1:0] op_a [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::SUM_W-1:0] op_b [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::PP_W-1:0]  pp_in [ssht_pkg::NUM_PROD][ssht_pkg::NUM_PP];
   logic [ssht_pkg::PP_W-1:0]  pp_ff [ssht_pkg::NUM_PROD][ssht_pkg::NUM_PP];

   // stage 5: cross sums
   logic [ssht_pkg::PP_W-1:0]    hh_ff [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::PP_W-1:0]    ll_ff [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::CROSS_W-1:0] cross_in [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::CROSS_W-1:0] cross_ff [ssht_pkg::NUM_PROD];

   // stage 6: full products
   logic [ssht_pkg::PROD_W-1:0] prod_in [ssht_pkg::NUM_PROD];
   logic [ssht_pkg::PROD_W-1:0] prod_ff [ssht_pkg::NUM_PROD];

   // stage 7: sides of the in-segment test
   logic [ssht_pkg::PROD_W-1:0] lhs_ff;
   logic [ssht_pkg::PROD_W:0]   rhs_in;
   logic [ssht_pkg::PROD_W:0]   rhs_ff;

   // stage 8: result
   logic hit_in;
   logic hit_ff;

   // ----- stage control -----
   always_comb begin
      stage_en[ssht_pkg::NUM_STAGES-1] = !stage_valid_ff[ssht_pkg::NUM_STAGES-1] || !rsp_stall;
      for (int k = ssht_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !stage_valid_ff[k] || stage_en[k+1];
      end
      stage_valid_in = {stage_valid_ff[ssht_pkg::NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int k = 0; k < ssht_pkg::NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = stage_valid_ff[ssht_pkg::NUM_STAGES-1];
   assign rsp_hit   = hit_ff;

   // ----- stage 1 -----
   always_comb begin
      d_in[0] = {req_cur_x[15], req_cur_x} - {req_prev_x[15], req_prev_x};
      d_in[1] = {req_cur_y[15], req_cur_y} - {req_prev_y[15], req_prev_y};
      d_in[2] = {req_cur_z[15], req_cur_z} - {req_prev_z[15], req_prev_z};
      w_in[0] = {req_target_x[15], req_target_x} - {req_prev_x[15], req_prev_x};
      w_in[1] = {req_target_y[15], req_target_y} - {req_prev_y[15], req_prev_y};
      w_in[2] = {req_target_z[15], req_target_z} - {req_prev_z[15], req_prev_z};
      e_in[0] = {req_target_x[15], req_target_x} - {req_cur_x[15], req_cur_x};
      e_in[1] = {req_target_y[15], req_target_y} - {req_cur_y[15], req_cur_y};
      e_in[2] = {req_target_z[15], req_target_z} - {req_cur_z[15], req_cur_z};
      rsum_in = {1'b0, req_mover_radius} + {1'b0, req_target_radius};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff    <= d_in;
         w_ff    <= w_in;
         e_ff    <= e_in;
         rsum_ff <= rsum_in;
      end
   end

   // ----- stage 2 -----
   always_comb begin
      for (int i = 0; i < ssht_pkg::AXES; i++) begin
         dd_full[i] = d_ff[i] * d_ff[i];
         ww_full[i] = w_ff[i] * w_ff[i];
         ee_full[i] = e_ff[i] * e_ff[i];
         wd_in[i]   = w_ff[i] * d_ff[i];
      end
      rsq_in = rsum_ff * rsum_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < ssht_pkg::AXES; i++) begin
            dd_ff[i] <= dd_full[i][ssht_pkg::SQ_W-1:0];
            ww_ff[i] <= ww_full[i][ssht_pkg::SQ_W-1:0];
            ee_ff[i] <= ee_full[i][ssht_pkg::SQ_W-1:0];
         end
         wd_ff  <= wd_in;
         rsq_ff <= rsq_in;
      end
   end

   // ----- stage 3 -----
   always_comb begin
      len2_in = {2'b00, dd_ff[0]} + {2'b00, dd_ff[1]} + {2'b00, dd_ff[2]};
      w2_in   = {2'b00, ww_ff[0]} + {2'b00, ww_ff[1]} + {2'b00, ww_ff[2]};
      e2_in   = {2'b00, ee_ff[0]} + {2'b00, ee_ff[1]} + {2'b00, ee_ff[2]};
      t_in    = {{2{wd_ff[0][ssht_pkg::DOT_W-1]}}, wd_ff[0]}
              + {{2{wd_ff[1][ssht_pkg::DOT_W-1]}}, wd_ff[1]}
              + {{2{wd_ff[2][ssht_pkg::DOT_W-1]}}, wd_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         len2_ff <= len2_in;
         w2_ff   <= w2_in;
         e2_ff   <= e2_in;
         t_ff    <= t_in;
         rsq3_ff <= rsq_ff;
      end
   end

   // ----- stage 4 -----
   always_comb begin
      f4_in.near     = t_ff[ssht_pkg::T_W-1] || (t_ff == '0);
      f4_in.far      = !f4_in.near && ($signed({1'b0, len2_ff}) <= t_ff);
      f4_in.near_hit = w2_ff <= {2'b00, rsq3_ff};
      f4_in.far_hit  = e2_ff <= {2'b00, rsq3_ff};

      op_a[ssht_pkg::PROD_WL] = w2_ff;
      op_b[ssht_pkg::PROD_WL] = len2_ff;
      op_a[ssht_pkg::PROD_RL] = {2'b00, rsq3_ff};
      op_b[ssht_pkg::PROD_RL] = len2_ff;
      op_a[ssht_pkg::PROD_TT] = t_ff[ssht_pkg::SUM_W-1:0];
      op_b[ssht_pkg::PROD_TT] = t_ff[ssht_pkg::SUM_W-1:0];

      for (int j = 0; j < ssht_pkg::NUM_PROD; j++) begin
         pp_in[j][ssht_pkg::PP_HH] = op_a[j][ssht_pkg::SUM_W-1:ssht_pkg::HALF_W]
                                   * op_b[j][ssht_pkg::SUM_W-1:ssht_pkg::HALF_W];
         pp_in[j][ssht_pkg::PP_HL] = op_a[j][ssht_pkg::SUM_W-1:ssht_pkg::HALF_W]
                                   * op_b[j][ssht_pkg::HALF_W-1:0];
         pp_in[j][ssht_pkg::PP_LH] = op_a[j][ssht_pkg::HALF_W-1:0]
                                   * op_b[j][ssht_pkg::SUM_W-1:ssht_pkg::HALF_W];
         pp_in[j][ssht_pkg::PP_LL] = op_a[j][ssht_pkg::HALF_W-1:0]
                                   * op_b[j][ssht_pkg::HALF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         f4_ff <= f4_in;
         pp_ff <= pp_in;
      end
   end

   // ----- stage 5 -----
   always_comb begin
      for (int j = 0; j < ssht_pkg::NUM_PROD; j++) begin
         cross_in[j] = {1'b0, pp_ff[j][ssht_pkg::PP_HL]} + {1'b0, pp_ff[j][ssht_pkg::PP_LH]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         f5_ff    <= f4_ff;
         cross_ff <= cross_in;
         for (int j = 0; j < ssht_pkg::NUM_PROD; j++) begin
            hh_ff[j] <= pp_ff[j][ssht_pkg::PP_HH];
            ll_ff[j] <= pp_ff[j][ssht_pkg::PP_LL];
         end
      end
   end

   // ----- stage 6 -----
   always_comb begin
      for (int j = 0; j < ssht_pkg::NUM_PROD; j++) begin
         prod_in[j] = {hh_ff[j], {ssht_pkg::PP_W{1'b0}}}
                    + {{(ssht_pkg::PROD_W - ssht_pkg::CROSS_W - ssht_pkg::HALF_W){1'b0}},
                       cross_ff[j], {ssht_pkg::HALF_W{1'b0}}}
                    + {{(ssht_pkg::PROD_W - ssht_pkg::PP_W){1'b0}}, ll_ff[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         f6_ff   <= f5_ff;
         prod_ff <= prod_in;
      end
   end

   // ----- stage 7 -----
   assign rhs_in = {1'b0, prod_ff[ssht_pkg::PROD_RL]} + {1'b0, prod_ff[ssht_pkg::PROD_TT]};

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         f7_ff  <= f6_ff;
         lhs_ff <= prod_ff[ssht_pkg::PROD_WL];
         rhs_ff <= rhs_in;
      end
   end

   // ----- stage 8 -----
   always_comb begin
      priority if (f7_ff.near) begin
         hit_in = f7_ff.near_hit;
      end else if (f7_ff.far) begin
         hit_in = f7_ff.far_hit;
      end else begin
         hit_in = {1'b0, lhs_ff} <= rhs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         hit_ff <= hit_in;
      end
   end

   // ----- assertions -----
   `ASSERT_ALWAYS(a_stall_only_when_full, clock, reset, !req_stall || (&stage_valid_ff))
   `ASSERT_NEXT(a_accept_fills_first, clock, reset, req_valid && !req_stall, stage_valid_ff[0])
   `ASSERT_ALWAYS(a_case_exclusive, clock, reset, !(stage_valid_ff[3] && f4_ff.near && f4_ff.far))

endmodule
